### hdl/gradient_concurrency_limit_defines.svh
// ----------------------------------------------------------------------------
// Gradient concurrency limit: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_CONCURRENCY_LIMIT_DEFINES_SVH
`define GRADIENT_CONCURRENCY_LIMIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GCL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gcl check failed");

// next-cycle implication, checked out of reset
`define GCL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gcl check failed");

`endif

### hdl/gcl_pkg.sv
// ----------------------------------------------------------------------------
// gcl_pkg
// Types and codes shared by the concurrency limit controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gcl_pkg;

    localparam int CNT_W = 6;

    // result action codes
    localparam logic [2:0] ACT_EMPTY  = 3'd0;
    localparam logic [2:0] ACT_SKIP   = 3'd1;
    localparam logic [2:0] ACT_PROBE  = 3'd2;
    localparam logic [2:0] ACT_NORMAL = 3'd3;
    localparam logic [2:0] ACT_DROP   = 3'd4;

    // register indexes
    localparam logic [2:0] REG_MIN_LIMIT  = 3'd0;
    localparam logic [2:0] REG_MAX_LIMIT  = 3'd1;
    localparam logic [2:0] REG_INIT_LIMIT = 3'd2;
    localparam logic [2:0] REG_SMOOTHING  = 3'd3;
    localparam logic [2:0] REG_TOLERANCE  = 3'd4;
    localparam logic [2:0] REG_PROBE_INTV = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_PREP,
        ST_ITER,
        ST_GROW,
        ST_SMOOTH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic prep;
        logic sq_en;
        logic mod_en;
        logic div_en;
        logic grow;
        logic smooth;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

### hdl/gcl_ctrl.sv
// ----------------------------------------------------------------------------
// gcl_ctrl
// Sequencer: steps one word through multiply, iterate and update phases.
// ----------------------------------------------------------------------------
`default_nettype none

module gcl_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    input  gcl_pkg::t_stat i_stat,
    output gcl_pkg::t_cmd  o_cmd
);
    import gcl_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL_LO;
                end
            end
            ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = ST_ITER;
            end
            ST_ITER: begin
                // sqrt needs 16 steps, modulo 32, divide all 64
                o_cmd.div_en = 1'b1;
                o_cmd.mod_en = (r_cnt[CNT_W-1] == 1'b0);
                o_cmd.sq_en  = (r_cnt[CNT_W-1:CNT_W-2] == 2'b00);
                n_cnt        = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_state = ST_GROW;
                end
            end
            ST_GROW: begin
                o_cmd.grow = 1'b1;
                n_state    = ST_SMOOTH;
            end
            ST_SMOOTH: begin
                o_cmd.smooth = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/gcl_dp.sv
// ----------------------------------------------------------------------------
// gcl_dp
// Datapath: registers, state, shared iterative sqrt/mod/divide and update.
// ----------------------------------------------------------------------------
`default_nettype none

module gcl_dp (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  gcl_pkg::t_cmd  i_cmd,
    output gcl_pkg::t_stat o_stat,
    input  wire            i_cfg_we,
    input  wire [2:0]      i_cfg_idx,
    input  wire [16:0]     i_cfg_data,
    input  wire [15:0]     i_sample_count,
    input  wire [39:0]     i_average_rtt_ns,
    input  wire [15:0]     i_peak_in_flight,
    input  wire            i_dropped,
    input  wire [31:0]     i_random_word,
    input  wire            i_stall,
    output logic           o_valid,
    output logic [15:0]    o_limit_out,
    output logic [2:0]     o_action,
    output logic [39:0]    o_min_rtt_out
);
    import gcl_pkg::*;

    // configuration
    logic [15:0] r_minl, r_maxl, r_tol, r_pi;
    logic [16:0] r_smooth;
    // block state
    logic [15:0] r_est;
    logic [39:0] r_min;
    logic        r_min_vld;
    logic [16:0] r_cd;
    logic        r_armed;
    // captured word
    logic        r_nonempty, r_drop;
    logic [39:0] r_rtt;
    logic [15:0] r_peak;
    // work registers
    logic [35:0] r_plo, r_phi;
    logic [63:0] r_num;
    logic [39:0] r_drem;
    logic [31:0] r_sq_x;
    logic [17:0] r_sq_r;
    logic [15:0] r_sq_q;
    logic [31:0] r_md_x;
    logic [15:0] r_md_r;
    logic [16:0] r_grow, r_nl, r_cd_next;
    logic [32:0] r_sa;
    logic [33:0] r_sb;
    logic        r_probe;
    // output register
    logic        r_o_vld;
    logic [15:0] r_o_limit;
    logic [2:0]  r_o_action;
    logic [39:0] r_o_min;

    logic [39:0] w_mnew;
    logic [16:0] w_s_c, w_one_minus, w_g, w_draw, w_cd0, w_cd1, w_nl;
    logic [40:0] w_drem;
    logic        w_dge;
    logic [19:0] w_sq_t, w_sq_trial;
    logic        w_sq_ge;
    logic [16:0] w_md_t;
    logic        w_md_ge;
    logic [33:0] w_lim_g, w_gsum;
    logic        w_probe;
    logic [34:0] w_sm_sum;
    logic [18:0] w_sm, w_lo, w_nla, w_nlb, w_nlc, w_qint;
    logic [2:0]  w_act;

    assign w_mnew      = (!r_min_vld || r_rtt < r_min) ? r_rtt : r_min;
    assign w_s_c       = (r_smooth > 17'd65536) ? 17'd65536 : r_smooth;
    assign w_one_minus = 17'd65536 - w_s_c;

    assign w_drem = {r_drem, r_num[63]};
    assign w_dge  = (w_drem >= {1'b0, r_rtt});

    assign w_sq_t     = {r_sq_r, r_sq_x[31:30]};
    assign w_sq_trial = {2'b00, r_sq_q, 2'b01};
    assign w_sq_ge    = (w_sq_t >= w_sq_trial);

    assign w_md_t  = {r_md_r, r_md_x[31]};
    assign w_md_ge = (w_md_t >= {1'b0, r_pi});

    // gradient clamped to [0.5, 1.0]; zero rtt means 1.0
    assign w_g = (r_rtt == 40'd0 || r_num > 64'd65536) ? 17'd65536 :
                 (r_num < 64'd32768) ? 17'd32768 : r_num[16:0];

    assign w_lim_g = 34'(r_est) * 34'(w_g);
    assign w_gsum  = w_lim_g + 34'({r_sq_q, 8'b0});

    assign w_draw  = 17'(r_pi) + 17'(r_md_r);
    assign w_cd0   = r_armed ? r_cd : w_draw;
    assign w_cd1   = (w_cd0 != 17'd0) ? w_cd0 - 17'd1 : 17'd0;
    assign w_probe = r_nonempty && (r_pi != 16'd0) && (w_cd1 == 17'd0);

    assign w_nl = r_drop ? {2'b00, r_est[15:1]} : r_grow;

    assign w_qint   = 19'(r_sq_q[15:8]);
    assign w_sm_sum = 35'(r_sa) + 35'(r_sb);
    assign w_sm     = w_sm_sum[34:16];
    assign w_lo     = (w_sm > 19'(r_minl)) ? w_sm : 19'(r_minl);
    assign w_nla    = (r_nl < 17'(r_est)) ? w_lo : 19'(r_nl);
    assign w_nlb    = (w_nla > 19'(r_maxl)) ? 19'(r_maxl) : w_nla;
    assign w_nlc    = (w_nlb < w_qint) ? w_qint : w_nlb;

    always_comb begin
        if (!r_nonempty) begin
            w_act = ACT_EMPTY;
        end else if (r_probe) begin
            w_act = ACT_PROBE;
        end else if (r_drop) begin
            w_act = ACT_DROP;
        end else if (r_peak < {1'b0, r_est[15:1]}) begin
            w_act = ACT_SKIP;
        end else begin
            w_act = ACT_NORMAL;
        end
    end

    // work registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_nonempty <= (i_sample_count != 16'd0);
            r_rtt      <= i_average_rtt_ns;
            r_peak     <= i_peak_in_flight;
            r_drop     <= i_dropped;
            r_md_x     <= i_random_word;
        end
        if (i_cmd.mul_lo) begin
            r_plo <= 36'(r_tol) * 36'(w_mnew[19:0]);
        end
        if (i_cmd.mul_hi) begin
            r_phi <= 36'(r_tol) * 36'(w_mnew[39:20]);
        end
        if (i_cmd.prep) begin
            r_num  <= {r_phi, 28'b0} + 64'({r_plo, 8'b0});
            r_drem <= '0;
            r_sq_x <= {r_est, 16'b0};
            r_sq_r <= '0;
            r_sq_q <= '0;
            r_md_r <= '0;
        end
        if (i_cmd.div_en) begin
            r_drem <= w_dge ? 40'(w_drem - {1'b0, r_rtt}) : w_drem[39:0];
            r_num  <= {r_num[62:0], w_dge};
        end
        if (i_cmd.sq_en) begin
            r_sq_r <= w_sq_ge ? 18'(w_sq_t - w_sq_trial) : w_sq_t[17:0];
            r_sq_q <= {r_sq_q[14:0], w_sq_ge};
            r_sq_x <= {r_sq_x[29:0], 2'b00};
        end
        if (i_cmd.mod_en) begin
            r_md_r <= w_md_ge ? 16'(w_md_t - {1'b0, r_pi}) : w_md_t[15:0];
            r_md_x <= {r_md_x[30:0], 1'b0};
        end
        if (i_cmd.grow) begin
            r_grow    <= w_gsum[32:16];
            r_sa      <= 33'(r_est) * 33'(w_one_minus);
            r_probe   <= w_probe;
            r_cd_next <= w_probe ? w_draw : w_cd1;
        end
        if (i_cmd.smooth) begin
            r_nl <= w_nl;
            r_sb <= 34'(w_s_c) * 34'(w_nl);
        end
        if (i_cmd.commit) begin
            r_o_action <= w_act;
            if (w_act == ACT_PROBE) begin
                r_o_limit <= (r_minl > 16'(w_qint)) ? r_minl : 16'(w_qint);
                r_o_min   <= '0;
            end else if (w_act == ACT_EMPTY) begin
                r_o_limit <= r_est;
                r_o_min   <= r_min_vld ? r_min : 40'd0;
            end else begin
                r_o_limit <= (w_act == ACT_SKIP) ? r_est : w_nlc[15:0];
                r_o_min   <= w_mnew;
            end
        end
    end

    // configuration and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minl    <= 16'd1;
            r_maxl    <= 16'd1000;
            r_smooth  <= 17'd13107;
            r_tol     <= 16'd512;
            r_pi      <= 16'd0;
            r_est     <= 16'd20;
            r_min     <= '0;
            r_min_vld <= 1'b0;
            r_cd      <= '0;
            r_armed   <= 1'b0;
            r_o_vld   <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_o_vld <= 1'b1;
            end else if (r_o_vld && !i_stall) begin
                r_o_vld <= 1'b0;
            end
            if (i_cmd.commit && r_nonempty) begin
                if (r_pi != 16'd0) begin
                    r_armed <= 1'b1;
                    r_cd    <= r_cd_next;
                end
                if (w_act == ACT_PROBE) begin
                    r_est     <= (r_minl > 16'(w_qint)) ? r_minl : 16'(w_qint);
                    r_min     <= '0;
                    r_min_vld <= 1'b0;
                end else begin
                    r_min     <= w_mnew;
                    r_min_vld <= 1'b1;
                    if (w_act != ACT_SKIP) begin
                        r_est <= w_nlc[15:0];
                    end
                end
            end else if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MIN_LIMIT:  r_minl   <= i_cfg_data[15:0];
                    REG_MAX_LIMIT:  r_maxl   <= i_cfg_data[15:0];
                    // the initial limit only matters as a load of the estimate
                    REG_INIT_LIMIT: r_est    <= i_cfg_data[15:0];
                    REG_SMOOTHING:  r_smooth <= i_cfg_data;
                    REG_TOLERANCE:  r_tol    <= i_cfg_data[15:0];
                    REG_PROBE_INTV: begin
                        r_pi    <= i_cfg_data[15:0];
                        r_armed <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_stat.out_free = !r_o_vld || !i_stall;
    assign o_valid         = r_o_vld;
    assign o_limit_out     = r_o_limit;
    assign o_action        = r_o_action;
    assign o_min_rtt_out   = r_o_min;

endmodule

`default_nettype wire

### hdl/gradient_concurrency_limit.sv
// ----------------------------------------------------------------------------
// gradient_concurrency_limit
// Adapts a concurrency limit from one sample-window summary word at a time.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel i_valid/o_stall carries one window summary per word; output
//  channel o_valid/i_stall returns one result word (limit, action, min rtt)
//  for every input word, in order. A word moves when valid is high and stall
//  is low.
//  After input accept a word passes the low and high multiply steps, the
//  setup step, 64 iterations of the shared divide unit (the square root and
//  modulo units run alongside in its first 16 and 32 steps), then the grow,
//  smooth and commit update steps. One word is in work at a time, so the
//  next word is taken only after the last one has committed its result.
//  The result register parts the two channels: a new word is taken while a
//  result waits; if the receiver still stalls when the next result is ready,
//  the block holds it and keeps o_stall high.
//  Reset (synchronous, active low) loads the register defaults, sets the
//  limit to the initial limit and clears the minimum and probe countdown.
//  Write configuration only while no word is in work.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_concurrency_limit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_idx,
    input  wire [16:0]  i_cfg_data,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire [15:0]  i_sample_count,
    input  wire [39:0]  i_average_rtt_ns,
    input  wire [15:0]  i_peak_in_flight,
    input  wire         i_dropped,
    input  wire [31:0]  i_random_word,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [15:0] o_limit_out,
    output logic [2:0]  o_action,
    output logic [39:0] o_min_rtt_out
);
    import gcl_pkg::*;

`include "gradient_concurrency_limit_defines.svh"

    t_cmd  w_cmd;
    t_stat w_stat;

    gcl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    gcl_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_sample_count   (i_sample_count),
        .i_average_rtt_ns (i_average_rtt_ns),
        .i_peak_in_flight (i_peak_in_flight),
        .i_dropped        (i_dropped),
        .i_random_word    (i_random_word),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_limit_out      (o_limit_out),
        .o_action         (o_action),
        .o_min_rtt_out    (o_min_rtt_out)
    );

    `GCL_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall)
    `GCL_ASSERT_IMPL(a_action_code, o_valid, o_action <= ACT_DROP)
    `GCL_ASSERT_IMPL(a_probe_clears_min, o_valid && o_action == ACT_PROBE, o_min_rtt_out == 40'd0)

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives window summaries into the concurrency limit estimator under random
// valid and stall gaps, predicts each result word in the bench and compares
// limit, action and minimum rtt in order. Runs several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import gcl_pkg::*;

    typedef struct packed {
        logic [15:0] count;
        logic [39:0] rtt;
        logic [15:0] peak;
        logic        drop;
        logic [31:0] rnd;
    } t_window;

    typedef struct packed {
        logic [15:0] limit;
        logic [2:0]  action;
        logic [39:0] min_rtt;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [16:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_sample_count = '0;
    logic [39:0] i_average_rtt_ns = '0;
    logic [15:0] i_peak_in_flight = '0;
    logic        i_dropped = 1'b0;
    logic [31:0] i_random_word = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_limit_out;
    logic [2:0]  o_action;
    logic [39:0] o_min_rtt_out;

    gradient_concurrency_limit u_top (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic [31:0] m_min_limit, m_max_limit, m_smoothing, m_tolerance, m_interval;
    logic [31:0] m_limit, m_countdown;
    logic [39:0] m_min_rtt;
    logic        m_min_valid, m_armed;

    t_window  window_q[$];
    t_result  result_q[$];
    int       mismatches = 0;
    bit       quiet = 1'b0;
    bit       hold_src = 1'b0;

    function automatic logic [31:0] int_sqrt(logic [31:0] x);
        logic [31:0] res, b;
        res = 0;
        b = 32'h4000_0000;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void set_reg(logic [2:0] idx, logic [16:0] val);
        case (idx)
            REG_MIN_LIMIT:  m_min_limit = val[15:0];
            REG_MAX_LIMIT:  m_max_limit = val[15:0];
            REG_INIT_LIMIT: m_limit = val[15:0];
            REG_SMOOTHING:  m_smoothing = val;
            REG_TOLERANCE:  m_tolerance = val[15:0];
            REG_PROBE_INTV: begin
                m_interval = val[15:0];
                m_armed = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function automatic t_result next_limit(t_window w);
        t_result r;
        logic [31:0] lim, q8, qint, nl, s, sm;
        logic [63:0] g;
        logic [2:0]  act;
        bit probed;
        act = ACT_EMPTY;
        nl = 0;
        if (w.count != 0) begin
            lim = m_limit;
            q8 = int_sqrt(lim << 16);
            qint = q8 >> 8;
            probed = 0;
            if (m_interval != 0) begin
                if (!m_armed) begin
                    m_countdown = m_interval + (w.rnd % m_interval);
                    m_armed = 1'b1;
                end
                if (m_countdown != 0) m_countdown--;
                if (m_countdown == 0) begin
                    m_countdown = m_interval + (w.rnd % m_interval);
                    m_limit = (m_min_limit > qint) ? m_min_limit : qint;
                    m_min_rtt = 0;
                    m_min_valid = 1'b0;
                    act = ACT_PROBE;
                    probed = 1;
                end
            end
            if (!probed) begin
                if (!m_min_valid || w.rtt < m_min_rtt) begin
                    m_min_rtt = w.rtt;
                    m_min_valid = 1'b1;
                end
                if (w.rtt == 0) begin
                    g = 64'd65536;
                end else begin
                    g = (64'(m_tolerance) * 64'(m_min_rtt) * 64'd256) / 64'(w.rtt);
                    if (g > 64'd65536) g = 64'd65536;
                    if (g < 64'd32768) g = 64'd32768;
                end
                if (w.drop) begin
                    nl = lim / 2;
                    act = ACT_DROP;
                end else if (32'(w.peak) < lim / 2) begin
                    act = ACT_SKIP;
                end else begin
                    nl = 32'((64'(lim) * g + (64'(q8) << 8)) >> 16);
                    act = ACT_NORMAL;
                end
                if (act != ACT_SKIP) begin
                    if (nl < lim) begin
                        s = (m_smoothing > 65536) ? 32'd65536 : m_smoothing;
                        sm = 32'((64'(lim) * 64'(65536 - s) + 64'(s) * 64'(nl)) >> 16);
                        nl = (m_min_limit > sm) ? m_min_limit : sm;
                    end
                    if (nl > m_max_limit) nl = m_max_limit;
                    if (nl < qint) nl = qint;
                    m_limit = nl & 32'hFFFF;
                end
            end
        end
        r.limit = m_limit[15:0];
        r.action = act;
        r.min_rtt = m_min_valid ? m_min_rtt : '0;
        return r;
    endfunction

    // driver: hold the word until accepted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (window_q.size() != 0 && !hold_src && (quiet || $urandom_range(99) >= 25))
                begin
                    t_window w;
                    w = window_q.pop_front();
                    result_q.push_back(next_limit(w));
                    i_valid <= 1'b1;
                    i_sample_count <= w.count;
                    i_average_rtt_ns <= w.rtt;
                    i_peak_in_flight <= w.peak;
                    i_dropped <= w.drop;
                    i_random_word <= w.rnd;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result word %h", o_limit_out);
                end else begin
                    t_result e;
                    e = result_q.pop_front();
                    if (e.limit !== o_limit_out || e.action !== o_action ||
                        e.min_rtt !== o_min_rtt_out) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp lim %0d act %0d rtt %0d, got %0d %0d %0d",
                                     e.limit, e.action, e.min_rtt,
                                     o_limit_out, o_action, o_min_rtt_out);
                    end
                end
            end
            i_stall <= quiet ? 1'b0 : ($urandom_range(99) < 25);
        end
    end

    function automatic t_window rand_window(int limit_hint);
        t_window w;
        w.count = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
        case ($urandom_range(3))
            0: w.rtt = {$urandom(), $urandom()};
            1: w.rtt = 40'($urandom_range(1000));
            default: w.rtt = 40'($urandom_range(100000, 400000));
        endcase
        if ($urandom_range(31) == 0) w.rtt = '0;
        w.peak = ($urandom_range(3) == 0) ? 16'($urandom())
                                          : 16'($urandom_range(limit_hint / 2, limit_hint + 8));
        w.drop = ($urandom_range(9) == 0);
        w.rnd = $urandom();
        return w;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [16:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        set_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (window_q.size() != 0 || result_q.size() != 0 || i_valid) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic run_random(int n);
        repeat (n) window_q.push_back(rand_window(m_limit));
        drain();
    endtask

    initial begin
        t_window w;
        m_min_limit = 1; m_max_limit = 1000; m_limit = 20; m_smoothing = 13107;
        m_tolerance = 512; m_interval = 0; m_min_rtt = 0; m_min_valid = 0;
        m_countdown = 0; m_armed = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty, zero rtt, extremes, drop, skip, growth
        w = '{16'd0, 40'd5, 16'd0, 1'b0, 32'd0};           window_q.push_back(w);
        w = '{16'd1, 40'd0, 16'hFFFF, 1'b0, 32'd0};         window_q.push_back(w);
        w = '{16'hFFFF, 40'hFF_FFFF_FFFF, 16'hFFFF, 1'b0, 32'hFFFF_FFFF};
        window_q.push_back(w);
        w = '{16'd5, 40'd100, 16'd50, 1'b0, 32'd7};         window_q.push_back(w);
        w = '{16'd5, 40'd1000, 16'd0, 1'b0, 32'd7};         window_q.push_back(w);
        w = '{16'd5, 40'd100, 16'd0, 1'b1, 32'd7};          window_q.push_back(w);
        w = '{16'd5, 40'd1, 16'd300, 1'b0, 32'd7};          window_q.push_back(w);
        drain();

        write_reg(REG_MIN_LIMIT, 17'd1);
        write_reg(REG_MAX_LIMIT, 17'd65535);
        write_reg(REG_INIT_LIMIT, 17'd65535);
        write_reg(REG_SMOOTHING, 17'd65536);
        write_reg(REG_TOLERANCE, 17'd65535);
        write_reg(REG_PROBE_INTV, 17'd1);
        w = '{16'd3, 40'd10, 16'hFFFF, 1'b0, 32'hFFFF_FFFF}; window_q.push_back(w);
        window_q.push_back(w);
        drain();
        write_reg(REG_PROBE_INTV, 17'd0);
        repeat (250) window_q.push_back(rand_window(m_limit));
        repeat (4000) @(posedge i_clk);

        // pause the sender mid-stream until all results are back
        hold_src = 1'b1;
        @(posedge i_clk);
        while (result_q.size() != 0 || i_valid) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        hold_src = 1'b0;
        drain();

        write_reg(REG_MIN_LIMIT, 17'd10);
        write_reg(REG_MAX_LIMIT, 17'd500);
        write_reg(REG_INIT_LIMIT, 17'd1);
        write_reg(REG_SMOOTHING, 17'd0);
        write_reg(REG_TOLERANCE, 17'd256);
        write_reg(REG_PROBE_INTV, 17'd7);
        quiet = 1'b1;
        run_random(250);
        quiet = 1'b0;

        write_reg(REG_SMOOTHING, 17'h1FFFF);
        write_reg(REG_MAX_LIMIT, 17'd1);
        write_reg(REG_PROBE_INTV, 17'd65535);
        run_random(200);

        write_reg(REG_MIN_LIMIT, 17'd65535);
        write_reg(REG_MAX_LIMIT, 17'd65535);
        write_reg(REG_INIT_LIMIT, 17'd300);
        write_reg(REG_SMOOTHING, 17'd40000);
        write_reg(REG_TOLERANCE, 17'd700);
        write_reg(REG_PROBE_INTV, 17'd3);
        run_random(250);

        write_reg(REG_MIN_LIMIT, 17'd2);
        write_reg(REG_INIT_LIMIT, 17'd100);
        write_reg(REG_PROBE_INTV, 17'd20);
        run_random(250);

        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
